[src/cbps_pkg.sv]
// ----------------------------------------------------------------------------
// cbps_pkg
// Shared types and codes for the cascade binary parity search core.
// ----------------------------------------------------------------------------
package cbps_pkg;

  localparam int KEY_BITS_DEF = 1024;

  // opcodes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_ANSWER = 2'd1;
  localparam logic [1:0] OP_NARROW = 2'd2;
  localparam logic [1:0] OP_FLIP   = 2'd3;

  // half codes, shared by partner responses and local answers
  localparam logic [1:0] CODE_LOWER = 2'd0;
  localparam logic [1:0] CODE_UPPER = 2'd1;
  localparam logic [1:0] CODE_NONE  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [9:0]  bit_index;
    logic        bit_value;
    logic [10:0] range_low;
    logic [10:0] range_high;
    logic        parity_low;
    logic        parity_high;
    logic [1:0]  response_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  mismatch_code;
    logic        error_found;
    logic [9:0]  error_index;
    logic [10:0] next_low;
    logic [10:0] next_high;
    logic        next_parity_low;
    logic        next_parity_high;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic mem_wr;
    logic mem_flip;
    logic mem_rd_idx;
    logic walk_init;
    logic walk_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       idx_ok;
    logic       range_ok;
    logic       code_ok;
    logic       walk_empty;
    logic       walk_last;
  } status_t;

endpackage

[src/cbps_if.sv]
// ----------------------------------------------------------------------------
// cbps_if
// Valid/ready channels for requests and results of the parity search core.
// ----------------------------------------------------------------------------
interface cbps_req_if;
  import cbps_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cbps_rsp_if;
  import cbps_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/cascade_binary_parity_search_core.sv]
// ----------------------------------------------------------------------------
// cascade_binary_parity_search_core
// One endpoint of the binary search step of cascade key reconciliation. The
// key is held in a bit-wide memory of KEY_BITS entries with no reset, with
// one write port and one registered read port; every entry must be written
// before it is read. A write is done from the decode state; a flip reads
// the bit there, then writes it back inverted from the flip write state.
// A parity answer or a narrow walks its range (the narrowed half for a
// narrow) one key bit per cycle through the memory read port, then drains
// the last read into the accumulators; an answer with a bad range goes
// straight to its result, and a narrow with a bad range or code gives no
// result. One request is worked on at a time; a finished result sits in
// an output register so the next request can be taken while it waits, but
// a request that ends in a second result holds until the first is taken.
// ----------------------------------------------------------------------------
module cascade_binary_parity_search_core #(
  parameter int KEY_BITS = cbps_pkg::KEY_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  cbps_req_if.sink   req,
  cbps_rsp_if.source rsp
);
  import cbps_pkg::*;

  cmd_t    cmd;
  status_t st;

  cbps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  cbps_dp #(
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (req.data),
    .cmd      (cmd),
    .st       (st),
    .out_data (rsp.data)
  );

endmodule

[src/cbps_ctrl.sv]
// ----------------------------------------------------------------------------
// cbps_ctrl
// Sequencer for key updates, parity walks and result hand-off.
// ----------------------------------------------------------------------------
module cbps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cbps_pkg::status_t st,
  output cbps_pkg::cmd_t    cmd
);
  import cbps_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_DECODE  = 6'b000010,
    S_FLIP_WR = 6'b000100,
    S_WALK    = 6'b001000,
    S_DRAIN   = 6'b010000,
    S_RESULT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        unique case (st.op)
          OP_WRITE: begin
            cmd.mem_wr = st.idx_ok;
          end
          OP_FLIP: begin
            if (st.idx_ok) begin
              cmd.mem_rd_idx = 1'b1;
              state_next     = S_FLIP_WR;
            end
          end
          OP_ANSWER: begin
            if (st.range_ok) begin
              cmd.walk_init = 1'b1;
              state_next    = S_WALK;
            end else begin
              state_next = S_RESULT;
            end
          end
          OP_NARROW: begin
            if (st.range_ok && st.code_ok) begin
              cmd.walk_init = 1'b1;
              state_next    = S_WALK;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_FLIP_WR: begin
        cmd.mem_wr   = 1'b1;
        cmd.mem_flip = 1'b1;
        state_next   = S_IDLE;
      end
      S_WALK: begin
        if (st.walk_empty) begin
          state_next = S_RESULT;
        end else begin
          cmd.walk_step = 1'b1;
          if (st.walk_last) begin
            state_next = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        // last read lands in the accumulators here
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[src/cbps_dp.sv]
// ----------------------------------------------------------------------------
// cbps_dp
// Key memory, range walker, half parity accumulators and result register.
// ----------------------------------------------------------------------------
module cbps_dp #(
  parameter int KEY_BITS = cbps_pkg::KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cbps_pkg::in_item_t  in_data,
  input  cbps_pkg::cmd_t      cmd,
  output cbps_pkg::status_t   st,
  output cbps_pkg::out_item_t out_data
);
  import cbps_pkg::*;

  localparam int ADDR_W = $clog2(KEY_BITS);

  logic mem [KEY_BITS];

  in_item_t    item;
  logic [10:0] cnt;
  logic [10:0] end_r;
  logic [10:0] mid_r;
  logic        rdata;
  logic        rd_pend;
  logic        rd_upper;
  logic        acc_lo;
  logic        acc_hi;
  out_item_t   res;
  out_item_t   res_next;

  logic [10:0]       lo;
  logic [10:0]       hi;
  logic [10:0]       mid;
  logic [10:0]       nl;
  logic [10:0]       nh;
  logic [10:0]       nm;
  logic [10:0]       walk_a;
  logic [10:0]       walk_b;
  logic [10:0]       walk_m;
  logic              range_ok;
  logic [ADDR_W-1:0] idx_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_data;
  logic              rd_en;
  logic              dl;
  logic              dh;
  logic [1:0]        ans_code;

  assign lo  = item.range_low;
  assign hi  = item.range_high;
  assign mid = 11'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign nl  = (item.response_code == CODE_LOWER) ? lo : mid;
  assign nh  = (item.response_code == CODE_LOWER) ? mid : hi;
  assign nm  = 11'(({1'b0, nl} + {1'b0, nh}) >> 1);

  assign walk_a = (item.opcode == OP_ANSWER) ? lo : nl;
  assign walk_b = (item.opcode == OP_ANSWER) ? hi : nh;
  assign walk_m = (item.opcode == OP_ANSWER) ? mid : nm;

  assign range_ok = (lo < hi) && (32'(hi) <= 32'(KEY_BITS));

  assign st.op         = item.opcode;
  assign st.idx_ok     = 32'(item.bit_index) < 32'(KEY_BITS);
  assign st.range_ok   = range_ok;
  assign st.code_ok    = (item.response_code == CODE_LOWER) ||
                         (item.response_code == CODE_UPPER);
  assign st.walk_empty = (cnt == end_r);
  assign st.walk_last  = ({1'b0, cnt} + 12'd1) == {1'b0, end_r};

  assign idx_addr = ADDR_W'(item.bit_index);
  assign rd_addr  = cmd.walk_step ? ADDR_W'(cnt) : idx_addr;
  assign rd_en    = cmd.walk_step || cmd.mem_rd_idx;
  assign wr_data  = cmd.mem_flip ? ~rdata : item.bit_value;

  // key memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[idx_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
    if (cmd.walk_init) begin
      cnt   <= walk_a;
      end_r <= walk_b;
      mid_r <= walk_m;
    end else if (cmd.walk_step) begin
      cnt <= cnt + 11'd1;
    end
    rd_upper <= (cnt >= mid_r);
    if (cmd.walk_init) begin
      acc_lo <= 1'b0;
      acc_hi <= 1'b0;
    end else if (rd_pend) begin
      if (rd_upper) begin
        acc_hi <= acc_hi ^ rdata;
      end else begin
        acc_lo <= acc_lo ^ rdata;
      end
    end
    if (cmd.out_load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.walk_step;
    end
  end

  assign dl = acc_lo ^ item.parity_low;
  assign dh = acc_hi ^ item.parity_high;

  always_comb begin
    if (dl && !dh) begin
      ans_code = CODE_LOWER;
    end else if (dh && !dl) begin
      ans_code = CODE_UPPER;
    end else begin
      ans_code = CODE_NONE;
    end
  end

  always_comb begin
    res_next               = '0;
    res_next.mismatch_code = CODE_NONE;
    if (item.opcode == OP_ANSWER) begin
      if (range_ok) begin
        res_next.mismatch_code = ans_code;
        // a two-bit range with one differing half pins the error down
        if ((ans_code != CODE_NONE) && ((hi - lo) == 11'd2)) begin
          res_next.error_found = 1'b1;
          res_next.error_index = 10'(lo + {10'd0, (ans_code == CODE_UPPER)});
        end
      end
    end else begin
      res_next.next_low         = nl;
      res_next.next_high        = nh;
      res_next.next_parity_low  = acc_lo;
      res_next.next_parity_high = acc_hi;
    end
  end

  assign out_data = res;

endmodule
